// ===== rtl/hhmm_pkg.sv =====
// Shared types, constants and the seven-segment decode for the HH:MM clock.
// Has no dependencies. Every other file of the block but hhmm_checker imports it.
`timescale 1ns / 1ps
`default_nettype none

package hhmm_pkg;

    localparam logic [15:0] RESET_PASSES       = 16'd400;
    localparam logic [5:0]  SECONDS_PER_MINUTE = 6'd60;
    localparam logic [7:0]  DOT_MASK           = 8'b0111_1111;

    // Button patterns that carry a meaning.
    localparam logic [6:0] BTN_NONE   = 7'd0;
    localparam logic [6:0] BTN_MINUTE = 7'd1;
    localparam logic [6:0] BTN_HOUR   = 7'd2;

    // Active-low common-anode segment codes, bit 7 is the dot.
    localparam logic [7:0] SEG_0     = 8'b1100_0000;
    localparam logic [7:0] SEG_1     = 8'b1111_1001;
    localparam logic [7:0] SEG_2     = 8'b1010_0100;
    localparam logic [7:0] SEG_3     = 8'b1011_0000;
    localparam logic [7:0] SEG_4     = 8'b1001_1001;
    localparam logic [7:0] SEG_5     = 8'b1001_0010;
    localparam logic [7:0] SEG_6     = 8'b1000_0010;
    localparam logic [7:0] SEG_7     = 8'b1111_1000;
    localparam logic [7:0] SEG_8     = 8'b1000_0000;
    localparam logic [7:0] SEG_9     = 8'b1001_0000;
    localparam logic [7:0] SEG_BLANK = 8'b1111_1111;

    typedef struct packed {
        logic [1:0] hour_tens;
        logic [3:0] hour_ones;
        logic [2:0] minute_tens;
        logic [3:0] minute_ones;
    } bcd_time_t;

    // What one accepted word does to the segment latch.
    typedef struct packed {
        logic fire;   // a second boundary was reached on this pass
        logic dot;    // the dot phase that goes with that latch
        logic press;  // a minute or hour set press was taken
    } latch_ctrl_t;

    function automatic logic [7:0] digit_code(input logic [3:0] digit);
        logic [7:0] code;
        case (digit)
            4'd0:    code = SEG_0;
            4'd1:    code = SEG_1;
            4'd2:    code = SEG_2;
            4'd3:    code = SEG_3;
            4'd4:    code = SEG_4;
            4'd5:    code = SEG_5;
            4'd6:    code = SEG_6;
            4'd7:    code = SEG_7;
            4'd8:    code = SEG_8;
            4'd9:    code = SEG_9;
            default: code = SEG_BLANK;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/hhmm_clock_seven_segment_unit.sv =====
// Top level of the HH:MM clock with seven-segment decode.
// Depends on hhmm_pkg, hhmm_time and hhmm_disp.
//
//   Channel   Handshake                Payload
//   item      item_valid / item_stall  buttons
//   result    result_valid / result_stall
//                                      seg_minute_ones, seg_minute_tens,
//                                      seg_hour_ones, seg_hour_tens, button_echo
//   config    cfg_valid / cfg_ready    cfg_data (passes_per_second)
//
// One word per cycle while item_stall is low; its result is in the result register in the next cycle.
// The time update and segment decode settle between the state registers and
// the result register in the cycle in which the word is accepted.
// item_stall is high only while a result waits and result_stall is high.
// rst_n clears the time to 00:00, the codes to digit zero and the rate to 400.
// cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module hhmm_clock_seven_segment_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output      logic        item_stall,
    input  wire logic [6:0]  buttons,
    output      logic        result_valid,
    input  wire logic        result_stall,
    output      logic [7:0]  seg_minute_ones,
    output      logic [7:0]  seg_minute_tens,
    output      logic [7:0]  seg_hour_ones,
    output      logic [7:0]  seg_hour_tens,
    output      logic [6:0]  button_echo,
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [15:0] cfg_data
);
    import hhmm_pkg::*;

    logic        accept;
    bcd_time_t   time_now;
    bcd_time_t   time_next;
    latch_ctrl_t ctrl;

    assign cfg_ready = 1'b1;

    hhmm_time u_time (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .buttons   (buttons),
        .time_now  (time_now),
        .time_next (time_next),
        .ctrl      (ctrl)
    );

    hhmm_disp u_disp (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .buttons         (buttons),
        .accept          (accept),
        .time_now        (time_now),
        .time_next       (time_next),
        .ctrl            (ctrl),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .seg_minute_ones (seg_minute_ones),
        .seg_minute_tens (seg_minute_tens),
        .seg_hour_ones   (seg_hour_ones),
        .seg_hour_tens   (seg_hour_tens),
        .button_echo     (button_echo)
    );

endmodule

`default_nettype wire

// ===== rtl/hhmm_time.sv =====
// Pass counter, dot phase, seconds and BCD time digits with the set buttons.
// Depends on hhmm_pkg for the digit struct, the latch control and constants.
`timescale 1ns / 1ps
`default_nettype none

module hhmm_time (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    input  wire logic [15:0]            cfg_data,
    input  wire logic                   accept,
    input  wire logic [6:0]             buttons,
    output hhmm_pkg::bcd_time_t         time_now,
    output hhmm_pkg::bcd_time_t         time_next,
    output hhmm_pkg::latch_ctrl_t       ctrl
);
    import hhmm_pkg::*;

    logic [15:0] pps_reg;
    logic [15:0] pass_count_reg, pass_count_next;
    logic        dot_phase_reg, dot_phase_next;
    logic [5:0]  seconds_reg, seconds_next;
    logic        press_held_reg, press_held_next;
    bcd_time_t   time_reg, time_mid;

    logic [15:0] count_inc;
    logic [5:0]  seconds_inc;
    logic        fire;
    logic        minute_press;
    logic        hour_press;

    function automatic bcd_time_t step_minutes(input bcd_time_t t);
        bcd_time_t r;
        r = t;
        r.minute_ones = t.minute_ones + 4'd1;
        if (r.minute_ones >= 4'd10)
        begin
            r.minute_ones = 4'd0;
            r.minute_tens = t.minute_tens + 3'd1;
        end
        if (r.minute_tens >= 3'd6)
        begin
            r.minute_tens = 3'd0;
        end
        return r;
    endfunction

    // Same test as step_minutes, telling whether the tens wrapped.
    function automatic logic minute_carry(input bcd_time_t t);
        logic [3:0] ones;
        logic [2:0] tens;
        ones = t.minute_ones + 4'd1;
        tens = t.minute_tens;
        if (ones >= 4'd10)
        begin
            tens = t.minute_tens + 3'd1;
        end
        return (tens >= 3'd6);
    endfunction

    function automatic bcd_time_t step_hours(input bcd_time_t t);
        bcd_time_t r;
        r = t;
        r.hour_ones = t.hour_ones + 4'd1;
        if (r.hour_ones >= 4'd10)
        begin
            r.hour_ones = 4'd0;
            r.hour_tens = t.hour_tens + 2'd1;
        end
        if (r.hour_tens >= 2'd2 && r.hour_ones >= 4'd4)
        begin
            r.hour_tens = 2'd0;
            r.hour_ones = 4'd0;
        end
        return r;
    endfunction

    always_comb
    begin
        count_inc   = pass_count_reg + 16'd1;
        fire        = (count_inc >= pps_reg);
        seconds_inc = seconds_reg + 6'd1;

        pass_count_next = fire ? 16'd0 : count_inc;
        dot_phase_next  = dot_phase_reg ^ fire;
        seconds_next    = seconds_reg;
        time_mid        = time_reg;
        if (fire)
        begin
            seconds_next = seconds_inc;
            if (seconds_inc >= SECONDS_PER_MINUTE)
            begin
                seconds_next = 6'd0;
                time_mid     = step_minutes(time_reg);
                if (minute_carry(time_reg))
                begin
                    time_mid = step_hours(time_mid);
                end
            end
        end

        minute_press    = (buttons == BTN_MINUTE) && !press_held_reg;
        hour_press      = (buttons == BTN_HOUR) && !press_held_reg;
        press_held_next = press_held_reg;
        time_next       = time_mid;
        if (minute_press)
        begin
            press_held_next = 1'b1;
            time_next       = step_minutes(time_mid);
        end
        else if (hour_press)
        begin
            press_held_next = 1'b1;
            time_next       = step_hours(time_mid);
        end
        else if (buttons == BTN_NONE)
        begin
            press_held_next = 1'b0;
        end
    end

    assign time_now = time_reg;
    assign ctrl     = '{fire: fire, dot: dot_phase_reg, press: minute_press | hour_press};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pps_reg        <= RESET_PASSES;
            pass_count_reg <= 16'd0;
            dot_phase_reg  <= 1'b0;
            seconds_reg    <= 6'd0;
            press_held_reg <= 1'b0;
            time_reg       <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                pps_reg <= cfg_data;
            end
            if (accept)
            begin
                pass_count_reg <= pass_count_next;
                dot_phase_reg  <= dot_phase_next;
                seconds_reg    <= seconds_next;
                press_held_reg <= press_held_next;
                time_reg       <= time_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hhmm_disp.sv =====
// Segment latch, result register and the word handshake on both channels.
// Depends on hhmm_pkg for the digit decode and the latch control struct.
`timescale 1ns / 1ps
`default_nettype none

module hhmm_disp (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   item_valid,
    output      logic                   item_stall,
    input  wire logic [6:0]             buttons,
    output      logic                   accept,
    input  wire hhmm_pkg::bcd_time_t    time_now,
    input  wire hhmm_pkg::bcd_time_t    time_next,
    input  wire hhmm_pkg::latch_ctrl_t  ctrl,
    output      logic                   result_valid,
    input  wire logic                   result_stall,
    output      logic [7:0]             seg_minute_ones,
    output      logic [7:0]             seg_minute_tens,
    output      logic [7:0]             seg_hour_ones,
    output      logic [7:0]             seg_hour_tens,
    output      logic [6:0]             button_echo
);
    import hhmm_pkg::*;

    logic [7:0] seg_mo_reg, seg_mo_next;
    logic [7:0] seg_mt_reg, seg_mt_next;
    logic [7:0] seg_ho_reg, seg_ho_next;
    logic [7:0] seg_ht_reg, seg_ht_next;
    logic [6:0] echo_reg;
    logic       valid_reg, valid_next;

    // A new word enters whenever no result waits or the waiting result leaves in the same cycle.
    assign item_stall = valid_reg & result_stall;
    assign accept     = item_valid & ~item_stall;

    always_comb
    begin
        seg_mo_next = seg_mo_reg;
        seg_mt_next = seg_mt_reg;
        seg_ho_next = seg_ho_reg;
        seg_ht_next = seg_ht_reg;
        // A press relatches from the stepped digits and overrides the second tick.
        if (ctrl.press)
        begin
            seg_mo_next = digit_code(time_next.minute_ones);
            seg_mt_next = digit_code({1'b0, time_next.minute_tens});
            seg_ho_next = digit_code(time_next.hour_ones);
            seg_ht_next = digit_code({2'b00, time_next.hour_tens});
        end
        else if (ctrl.fire)
        begin
            seg_mo_next = digit_code(time_now.minute_ones) & (ctrl.dot ? DOT_MASK : SEG_BLANK);
            seg_mt_next = digit_code({1'b0, time_now.minute_tens});
            seg_ho_next = digit_code(time_now.hour_ones);
            seg_ht_next = digit_code({2'b00, time_now.hour_tens});
        end
        valid_next = accept | (valid_reg & result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            seg_mo_reg <= SEG_0;
            seg_mt_reg <= SEG_0;
            seg_ho_reg <= SEG_0;
            seg_ht_reg <= SEG_0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (accept)
            begin
                seg_mo_reg <= seg_mo_next;
                seg_mt_reg <= seg_mt_next;
                seg_ho_reg <= seg_ho_next;
                seg_ht_reg <= seg_ht_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            echo_reg <= buttons;
        end
    end

    assign result_valid    = valid_reg;
    assign seg_minute_ones = seg_mo_reg;
    assign seg_minute_tens = seg_mt_reg;
    assign seg_hour_ones   = seg_ho_reg;
    assign seg_hour_tens   = seg_ht_reg;
    assign button_echo     = echo_reg;

endmodule

`default_nettype wire

// ===== rtl/hhmm_checker.sv =====
// Port-level checks for the HH:MM clock, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module hhmm_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       item_valid,
    input wire logic       item_stall,
    input wire logic [6:0] buttons,
    input wire logic       result_valid,
    input wire logic       result_stall,
    input wire logic [7:0] seg_minute_ones,
    input wire logic [7:0] seg_minute_tens,
    input wire logic [7:0] seg_hour_ones,
    input wire logic [7:0] seg_hour_tens,
    input wire logic [6:0] button_echo
);

    // A stalled result stays valid.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("stalled result dropped");

    // A stalled result keeps its minute ones and hour tens segment codes.
    a_codes_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(seg_minute_ones) && $stable(seg_hour_tens))
        else $error("stalled result changed");

    // Every accepted word produces a result that echoes its buttons.
    a_word_echo: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> result_valid && button_echo == $past(buttons))
        else $error("accepted word has no matching result");

    // The input side is never held off while the result register is free.
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !item_stall)
        else $error("input stalled with empty result register");

    // Only the minute ones digit ever shows the dot.
    a_dot_place: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> seg_minute_tens[7] && seg_hour_ones[7] && seg_hour_tens[7])
        else $error("dot lit on the wrong digit");

endmodule

bind hhmm_clock_seven_segment_unit hhmm_checker u_hhmm_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .buttons         (buttons),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .seg_minute_ones (seg_minute_ones),
    .seg_minute_tens (seg_minute_tens),
    .seg_hour_ones   (seg_hour_ones),
    .seg_hour_tens   (seg_hour_tens),
    .button_echo     (button_echo)
);

`default_nettype wire
